FILE: hw/rtl/rswd_pkg.sv
// Shared types, widths and constants for the ray to square wall distance block.
`default_nettype none
package rswd_pkg;
  localparam int XyW  = 33;
  localparam int ZW   = 25;
  localparam int PosW = 24;
  localparam int HalfW = 23;
  localparam int CsW  = 18;
  localparam int NW   = 26;
  localparam int MulW = 44;
  localparam int DenW = 17;
  localparam int RemW = 18;
  localparam int DistW = 24;
  localparam int NumLoW = 9;
  localparam int CordicSteps = 16;

  localparam logic signed [XyW-1:0] CordicX0 = 33'sd652032874;
  localparam logic signed [CsW-1:0] CompMin = 18'sd3;
  localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

  typedef struct packed {
    logic signed [PosW-1:0] px;
    logic signed [PosW-1:0] py;
    logic [HalfW-1:0]       h;
    logic [1:0]             quad;
  } rswd_ray_t;

  typedef struct packed {
    logic                   en;
    logic signed [NW-1:0]   n;
    logic signed [CsW-1:0]  a;
    logic signed [CsW-1:0]  b;
    logic signed [PosW-1:0] q;
  } rswd_wall_t;

  typedef struct packed {
    logic                   ok;
    logic signed [NW-1:0]   n;
    logic signed [CsW-1:0]  a;
    logic signed [MulW-1:0] lhs;
    logic signed [MulW-1:0] lo;
    logic signed [MulW-1:0] hi;
  } rswd_prod_t;

  typedef struct packed {
    logic              hit;
    logic              sat;
    logic [RemW-1:0]   rem;
    logic [DenW-1:0]   den;
    logic [NumLoW-1:0] num_lo;
    logic [DistW-1:0]  quo;
  } rswd_div_t;

  function automatic logic signed [ZW-1:0] atan_lut(input logic [3:0] idx);
    logic signed [ZW-1:0] v;
    case (idx)
      4'd0:  v = 25'sd2097152;
      4'd1:  v = 25'sd1238021;
      4'd2:  v = 25'sd654136;
      4'd3:  v = 25'sd332050;
      4'd4:  v = 25'sd166669;
      4'd5:  v = 25'sd83416;
      4'd6:  v = 25'sd41718;
      4'd7:  v = 25'sd20860;
      4'd8:  v = 25'sd10430;
      4'd9:  v = 25'sd5215;
      4'd10: v = 25'sd2608;
      4'd11: v = 25'sd1304;
      4'd12: v = 25'sd652;
      4'd13: v = 25'sd326;
      4'd14: v = 25'sd163;
      default: v = 25'sd81;
    endcase
    return v;
  endfunction
endpackage
`default_nettype wire

FILE: hw/rtl/rswd_cordic_cell.sv
// One CORDIC rotation step with its carried ray word.
`default_nettype none
module rswd_cordic_cell #(
  parameter int STEP = 0
) (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [rswd_pkg::XyW-1:0]     x_i,
  input  wire logic signed [rswd_pkg::XyW-1:0]     y_i,
  input  wire logic signed [rswd_pkg::ZW-1:0]      z_i,
  input  wire rswd_pkg::rswd_ray_t                 ray_i,
  output logic signed [rswd_pkg::XyW-1:0]          x_r,
  output logic signed [rswd_pkg::XyW-1:0]          y_r,
  output logic signed [rswd_pkg::ZW-1:0]           z_r,
  output rswd_pkg::rswd_ray_t                      ray_r
);
  logic signed [rswd_pkg::XyW-1:0] dx, dy, x_nxt, y_nxt;
  logic signed [rswd_pkg::ZW-1:0]  at, z_nxt;

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    at = rswd_pkg::atan_lut(4'(STEP));
    if (!z_i[rswd_pkg::ZW-1]) begin
      x_nxt = x_i - dx;
      y_nxt = y_i + dy;
      z_nxt = z_i - at;
    end else begin
      x_nxt = x_i + dx;
      y_nxt = y_i - dy;
      z_nxt = z_i + at;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      y_r   <= y_nxt;
      z_r   <= z_nxt;
      ray_r <= ray_i;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/rswd_div_cell.sv
// One restoring division step for one wall lane.
`default_nettype none
module rswd_div_cell #(
  parameter int BIT = 23
) (
  input  wire logic                clk,
  input  wire logic                en,
  input  wire rswd_pkg::rswd_div_t d_i,
  output rswd_pkg::rswd_div_t      d_r
);
  rswd_pkg::rswd_div_t d_nxt;
  logic                  nb;
  logic [rswd_pkg::RemW-1:0] sh;

  always_comb begin
    if (BIT >= 15) begin
      nb = d_i.num_lo[(BIT >= 15) ? (BIT - 15) : 0];
    end else begin
      nb = 1'b0;
    end
    sh    = {d_i.rem[rswd_pkg::RemW-2:0], nb};
    d_nxt = d_i;
    if (sh >= {1'b0, d_i.den}) begin
      d_nxt.rem      = sh - {1'b0, d_i.den};
      d_nxt.quo[BIT] = 1'b1;
    end else begin
      d_nxt.rem      = sh;
      d_nxt.quo[BIT] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_r <= d_nxt;
    end
  end
endmodule
`default_nettype wire

FILE: hw/rtl/ray_square_wall_distance_top.sv
// Top level: ray to square wall distance pipeline with APB register port.
//
// Channel | Direction | Ports
// in      | input     | in_valid, in_ready, in_pos_x, in_pos_y, in_heading
// out     | output    | out_valid, out_ready, out_wall_hit, out_distance
// cfg     | APB       | cfg_psel, cfg_penable, cfg_pwrite, cfg_paddr, cfg_pwdata, ...
//
// One word per cycle while out_ready holds; 16 CORDIC cells, 24 divider cells.
// Each stage holds a valid bit; a stage loads when empty or when its successor loads,
// so bubbles collapse and input is taken while a result waits.
// Reset clears valid bits and sets field_half to 72 inches.
`default_nettype none
module ray_square_wall_distance_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic signed [23:0] in_pos_x,
  input  wire logic signed [23:0] in_pos_y,
  input  wire logic [15:0] in_heading,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_wall_hit,
  output logic [23:0]      out_distance,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  localparam int NSTG   = 46;
  localparam int SROT   = 17;
  localparam int SW1    = 18;
  localparam int SW2    = 19;
  localparam int SW3    = 20;
  localparam int SDIV   = 21;
  localparam int SOUT   = 45;
  localparam logic RegFieldHalf = 1'b0;

  logic [NSTG-1:0] v_r, v_nxt;
  logic [NSTG:0]   rdy;

  logic [rswd_pkg::HalfW-1:0] half_r;

  // config port
  assign cfg_pready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 23'd18432;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == RegFieldHalf)) begin
      half_r <= cfg_pwdata[rswd_pkg::HalfW-1:0];
    end
  end
  assign cfg_prdata = (cfg_paddr[2] == RegFieldHalf) ? {9'd0, half_r} : 32'd0;

  // handshake chain
  assign rdy[NSTG] = out_ready;
  genvar g;
  generate
    for (g = 0; g < NSTG; g++) begin : g_rdy
      assign rdy[g] = !v_r[g] || rdy[g+1];
    end
  endgenerate
  assign in_ready = rdy[0];

  always_comb begin
    for (int i = 0; i < NSTG; i++) begin
      if (rdy[i]) begin
        v_nxt[i] = (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
      end else begin
        v_nxt[i] = v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  // input stage
  rswd_pkg::rswd_ray_t ray0_r;
  logic [13:0]         ang_r;
  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      ray0_r <= '{px: in_pos_x, py: in_pos_y, h: half_r, quad: in_heading[15:14]};
      ang_r  <= in_heading[13:0];
    end
  end

  // CORDIC chain
  logic signed [rswd_pkg::XyW-1:0] cx [rswd_pkg::CordicSteps+1];
  logic signed [rswd_pkg::XyW-1:0] cy [rswd_pkg::CordicSteps+1];
  logic signed [rswd_pkg::ZW-1:0]  cz [rswd_pkg::CordicSteps+1];
  rswd_pkg::rswd_ray_t             cr [rswd_pkg::CordicSteps+1];

  assign cx[0] = rswd_pkg::CordicX0;
  assign cy[0] = '0;
  assign cz[0] = $signed({3'b000, ang_r, 8'd0});
  assign cr[0] = ray0_r;

  generate
    for (g = 0; g < rswd_pkg::CordicSteps; g++) begin : g_cordic
      rswd_cordic_cell #(.STEP(g)) u_cell (
        .clk(clk), .en(rdy[1+g]),
        .x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]), .ray_i(cr[g]),
        .x_r(cx[g+1]), .y_r(cy[g+1]), .z_r(cz[g+1]), .ray_r(cr[g+1])
      );
    end
  endgenerate

  // round and rotate by quadrant
  logic signed [rswd_pkg::XyW-1:0] xr_full, yr_full;
  logic signed [rswd_pkg::CsW-1:0] c0, s0, s_nxt, c_nxt, s_r, c_r;
  rswd_pkg::rswd_ray_t             rot_ray_r;
  always_comb begin
    xr_full = (cx[rswd_pkg::CordicSteps] + 33'sd16384) >>> 15;
    yr_full = (cy[rswd_pkg::CordicSteps] + 33'sd16384) >>> 15;
    c0 = xr_full[rswd_pkg::CsW-1:0];
    s0 = yr_full[rswd_pkg::CsW-1:0];
    case (cr[rswd_pkg::CordicSteps].quad)
      2'd0: begin c_nxt = c0;  s_nxt = s0;  end
      2'd1: begin c_nxt = -s0; s_nxt = c0;  end
      2'd2: begin c_nxt = -c0; s_nxt = -s0; end
      default: begin c_nxt = s0; s_nxt = -c0; end
    endcase
  end
  always_ff @(posedge clk) begin
    if (rdy[SROT]) begin
      s_r       <= s_nxt;
      c_r       <= c_nxt;
      rot_ray_r <= cr[rswd_pkg::CordicSteps];
    end
  end

  // wall setup: lane 0 east/west, lane 1 north/south
  logic signed [rswd_pkg::NW-1:0] h_e, px_e, py_e;
  rswd_pkg::rswd_wall_t w_nxt [2];
  rswd_pkg::rswd_wall_t w_r [2];
  logic [rswd_pkg::HalfW-1:0] h1_r;
  always_comb begin
    h_e  = $signed({3'b000, rot_ray_r.h});
    px_e = {{2{rot_ray_r.px[23]}}, rot_ray_r.px};
    py_e = {{2{rot_ray_r.py[23]}}, rot_ray_r.py};
    w_nxt[0].en = (s_r > rswd_pkg::CompMin) || (s_r < -rswd_pkg::CompMin);
    w_nxt[0].n  = s_r[rswd_pkg::CsW-1] ? (h_e + px_e) : (h_e - px_e);
    w_nxt[0].a  = s_r[rswd_pkg::CsW-1] ? -s_r : s_r;
    w_nxt[0].b  = s_r[rswd_pkg::CsW-1] ? -c_r : c_r;
    w_nxt[0].q  = rot_ray_r.py;
    w_nxt[1].en = (c_r > rswd_pkg::CompMin) || (c_r < -rswd_pkg::CompMin);
    w_nxt[1].n  = c_r[rswd_pkg::CsW-1] ? (h_e + py_e) : (h_e - py_e);
    w_nxt[1].a  = c_r[rswd_pkg::CsW-1] ? -c_r : c_r;
    w_nxt[1].b  = c_r[rswd_pkg::CsW-1] ? -s_r : s_r;
    w_nxt[1].q  = rot_ray_r.px;
  end
  always_ff @(posedge clk) begin
    if (rdy[SW1]) begin
      w_r[0] <= w_nxt[0];
      w_r[1] <= w_nxt[1];
      h1_r   <= rot_ray_r.h;
    end
  end

  // span products
  rswd_pkg::rswd_prod_t p_nxt [2];
  rswd_pkg::rswd_prod_t p_r [2];
  logic signed [rswd_pkg::NW-1:0] h1_e, q_e [2];
  always_comb begin
    h1_e = $signed({3'b000, h1_r});
    for (int l = 0; l < 2; l++) begin
      q_e[l]      = {{2{w_r[l].q[23]}}, w_r[l].q};
      p_nxt[l].ok = w_r[l].en && (w_r[l].n > 0);
      p_nxt[l].n  = w_r[l].n;
      p_nxt[l].a  = w_r[l].a;
      p_nxt[l].lhs = rswd_pkg::MulW'(w_r[l].n) * rswd_pkg::MulW'(w_r[l].b);
      p_nxt[l].lo  = rswd_pkg::MulW'(-h1_e - q_e[l]) * rswd_pkg::MulW'(w_r[l].a);
      p_nxt[l].hi  = rswd_pkg::MulW'(h1_e - q_e[l]) * rswd_pkg::MulW'(w_r[l].a);
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[SW2]) begin
      p_r[0] <= p_nxt[0];
      p_r[1] <= p_nxt[1];
    end
  end

  // span check and divider seed
  rswd_pkg::rswd_div_t dv [25][2];
  rswd_pkg::rswd_div_t seed_nxt [2];
  logic [rswd_pkg::NW-1:0] nu [2];
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      nu[l] = p_r[l].n;
      seed_nxt[l].hit    = p_r[l].ok && !(p_r[l].lhs < p_r[l].lo) && !(p_r[l].lhs > p_r[l].hi);
      seed_nxt[l].den    = p_r[l].a[rswd_pkg::DenW-1:0];
      seed_nxt[l].sat    = nu[l] >= {p_r[l].a[rswd_pkg::DenW-1:0], 9'd0};
      seed_nxt[l].rem    = {1'b0, nu[l][25:9]};
      seed_nxt[l].num_lo = nu[l][8:0];
      seed_nxt[l].quo    = '0;
    end
  end
  rswd_pkg::rswd_div_t seed_r [2];
  always_ff @(posedge clk) begin
    if (rdy[SW3]) begin
      seed_r[0] <= seed_nxt[0];
      seed_r[1] <= seed_nxt[1];
    end
  end
  assign dv[0][0] = seed_r[0];
  assign dv[0][1] = seed_r[1];

  // divider chain
  generate
    for (g = 0; g < 24; g++) begin : g_div
      genvar l;
      for (l = 0; l < 2; l++) begin : g_lane
        rswd_div_cell #(.BIT(23 - g)) u_cell (
          .clk(clk), .en(rdy[SDIV+g]),
          .d_i(dv[g][l]),
          .d_r(dv[g+1][l])
        );
      end
    end
  endgenerate

  // nearest wall
  logic [rswd_pkg::DistW-1:0] dd [2];
  logic                       hit_nxt, hit_r;
  logic [rswd_pkg::DistW-1:0] dist_nxt, dist_r;
  always_comb begin
    for (int l = 0; l < 2; l++) begin
      dd[l] = dv[24][l].sat ? rswd_pkg::DistMax : dv[24][l].quo;
    end
    hit_nxt = dv[24][0].hit || dv[24][1].hit;
    if (dv[24][0].hit && dv[24][1].hit) begin
      dist_nxt = (dd[0] < dd[1]) ? dd[0] : dd[1];
    end else if (dv[24][0].hit) begin
      dist_nxt = dd[0];
    end else if (dv[24][1].hit) begin
      dist_nxt = dd[1];
    end else begin
      dist_nxt = '0;
    end
  end
  always_ff @(posedge clk) begin
    if (rdy[SOUT]) begin
      hit_r  <= hit_nxt;
      dist_r <= dist_nxt;
    end
  end

  assign out_valid    = v_r[SOUT];
  assign out_wall_hit = hit_r;
  assign out_distance = dist_r;

  a_nohit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_wall_hit |-> out_distance == '0)
    else $error("distance nonzero without hit");
  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !v_r[SOUT] |-> in_ready)
    else $error("input stalled with empty output stage");
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> v_r[0] && v_r[1])
    else $error("input stalled while next stage empty");
endmodule
`default_nettype wire
